// ===== rtl/core/uds_fault_table_responder_core_macros.svh =====
// Assertion macros shared by the fault table responder RTL.
`ifndef UDS_FAULT_TABLE_RESPONDER_CORE_MACROS_SVH
`define UDS_FAULT_TABLE_RESPONDER_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define UFR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define UFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent checked after the antecedent, later than in UFR_ASSERT_NEXT
`define UFR_ASSERT_LATER(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##1 (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ufr_pkg.sv =====
// Package: constants, field layout and controller/datapath interface types.
`timescale 1ns / 1ps
package ufr_pkg;

  // Table size and response limits
  localparam int NUM_FAULTS  = 5;
  localparam int MAX_RESULTS = 16;
  localparam int MAX_TRIPLES = (MAX_RESULTS - 1) / 3;
  localparam int PTR_W       = (NUM_FAULTS > 1) ? $clog2(NUM_FAULTS) : 1;
  localparam int TRIP_W      = $clog2(MAX_TRIPLES + 1);

  // Field widths and tdata layout
  localparam int CMD_W       = 2;
  localparam int IDX_W       = 3;
  localparam int LEN_W       = 2;
  localparam int BYTE_W      = 8;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;
  localparam int IDX_LSB     = 0;
  localparam int LEN_LSB     = IDX_LSB + IDX_W;
  localparam int SID_LSB     = LEN_LSB + LEN_W;
  localparam int SUB_LSB     = SID_LSB + BYTE_W;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_RECORD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd2;

  // Service identifiers and response bytes
  localparam logic [BYTE_W-1:0] SID_SESSION       = 8'h10;
  localparam logic [BYTE_W-1:0] SID_READ_DTC      = 8'h19;
  localparam logic [BYTE_W-1:0] SID_CLEAR_DTC     = 8'h14;
  localparam logic [BYTE_W-1:0] RSP_SESSION       = 8'h50;
  localparam logic [BYTE_W-1:0] RSP_READ_DTC      = 8'h59;
  localparam logic [BYTE_W-1:0] RSP_CLEAR_DTC     = 8'h54;
  localparam logic [BYTE_W-1:0] NEG_RESPONSE      = 8'h7F;
  localparam logic [BYTE_W-1:0] NRC_NOT_SUPPORTED = 8'h11;
  localparam logic [BYTE_W-1:0] NRC_BAD_LENGTH    = 8'h13;
  localparam logic [BYTE_W-1:0] STATUS_ACTIVE     = 8'h01;
  localparam logic [15:0]       FAULT_CODE_BASE   = 16'hC001;

  // Byte positions inside a message or a fault triple
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic flag_set;
    logic flag_clr;
    logic capture;
    logic emit_msg;
    logic emit_trip;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
    logic msg_last;
    logic dtc_more;
    logic trip_end;
    logic trip_more;
  } dp_sts_t;

endpackage

// ===== rtl/core/ufr_ctrl.sv =====
// Controller: sequences item acceptance and response byte emission.
`timescale 1ns / 1ps
module ufr_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [ufr_pkg::CMD_W-1:0] in_command,
  input  logic                    in_len_nz,
  input  ufr_pkg::dp_sts_t        sts,
  output ufr_pkg::dp_cmd_t        cmd
);
  import ufr_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MSG, S_TRIP} state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_RECORD: cmd.flag_set = 1'b1;
            CMD_CLEAR:  cmd.flag_clr = 1'b1;
            CMD_REQUEST: begin
              if (in_len_nz) begin
                cmd.capture = 1'b1;
                state_nxt   = S_MSG;
              end
            end
            default: ;
          endcase
        end
      end
      S_MSG: begin
        if (sts.out_free) begin
          cmd.emit_msg = 1'b1;
          if (sts.msg_last) begin
            state_nxt = sts.dtc_more ? S_TRIP : S_IDLE;
          end
        end
      end
      S_TRIP: begin
        if (sts.out_free) begin
          cmd.emit_trip = 1'b1;
          if (sts.trip_end && !sts.trip_more) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/ufr_dp.sv =====
// Datapath: fault flags, captured request, response byte generation, output register.
`timescale 1ns / 1ps
module ufr_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ufr_pkg::dp_cmd_t              cmd,
  input  logic [ufr_pkg::IDX_W-1:0]     fault_index,
  input  logic [ufr_pkg::LEN_W-1:0]     request_length,
  input  logic [ufr_pkg::BYTE_W-1:0]    service_id,
  input  logic [ufr_pkg::BYTE_W-1:0]    sub_function,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic [ufr_pkg::BYTE_W-1:0]    response_byte,
  output logic                          last_byte,
  output ufr_pkg::dp_sts_t              sts
);
  import ufr_pkg::*;

  // Lowest active fault at or above start; result is {hit, index}
  function automatic logic [PTR_W:0] find_from(input logic [NUM_FAULTS-1:0] flags,
                                               input int start);
    logic             hit;
    logic [PTR_W-1:0] idx;
    hit = 1'b0;
    idx = '0;
    for (int i = NUM_FAULTS - 1; i >= 0; i--) begin
      if (flags[i] && (i >= start)) begin
        hit = 1'b1;
        idx = PTR_W'(i);
      end
    end
    return {hit, idx};
  endfunction

  logic [NUM_FAULTS-1:0] flags_r;
  logic [BYTE_W-1:0]     sid_r, sub_r;
  logic                  has_sub_r;
  logic [1:0]            pos_r;
  logic [PTR_W-1:0]      ptr_r;
  logic [TRIP_W-1:0]     trip_r;
  logic                  out_valid_r, out_last_r;
  logic [BYTE_W-1:0]     out_byte_r;

  logic [PTR_W:0]        first_fa, after_fa;
  logic                  is_session, is_dtc, is_clear, is_neg;
  logic [1:0]            msg_last_pos;
  logic [BYTE_W-1:0]     msg_byte, trip_byte;
  logic [15:0]           code;
  logic                  emit;

  // Service decode of the captured request
  assign is_session = (sid_r == SID_SESSION);
  assign is_dtc     = (sid_r == SID_READ_DTC);
  assign is_clear   = (sid_r == SID_CLEAR_DTC);
  assign is_neg     = !(is_session && has_sub_r) && !is_dtc && !is_clear;

  // Active fault search: from the table start, and past the current pointer
  assign first_fa = find_from(flags_r, 0);
  assign after_fa = find_from(flags_r, int'(ptr_r) + 1);

  // Fixed message bytes
  always_comb begin
    if (is_dtc || is_clear) begin
      msg_last_pos = POS_FIRST;
    end else if (is_session && has_sub_r) begin
      msg_last_pos = POS_SECOND;
    end else begin
      msg_last_pos = POS_THIRD;
    end
    case (pos_r)
      POS_FIRST: begin
        if (is_neg) begin
          msg_byte = NEG_RESPONSE;
        end else if (is_session) begin
          msg_byte = RSP_SESSION;
        end else if (is_dtc) begin
          msg_byte = RSP_READ_DTC;
        end else begin
          msg_byte = RSP_CLEAR_DTC;
        end
      end
      POS_SECOND: msg_byte = is_neg ? sid_r : sub_r;
      default:    msg_byte = is_session ? NRC_BAD_LENGTH : NRC_NOT_SUPPORTED;
    endcase
  end

  // Fault triple bytes: code high, code low, status
  assign code = FAULT_CODE_BASE + 16'(ptr_r);
  always_comb begin
    case (pos_r)
      POS_FIRST:  trip_byte = code[15:8];
      POS_SECOND: trip_byte = code[7:0];
      default:    trip_byte = STATUS_ACTIVE;
    endcase
  end

  // Status to the controller
  assign sts.out_free  = !out_valid_r || out_tready;
  assign sts.msg_last  = (pos_r == msg_last_pos);
  assign sts.dtc_more  = is_dtc && first_fa[PTR_W];
  assign sts.trip_end  = (pos_r == POS_THIRD);
  assign sts.trip_more = after_fa[PTR_W] && ((int'(trip_r) + 1) < MAX_TRIPLES);

  assign emit = cmd.emit_msg || cmd.emit_trip;

  // Fault flags and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_FAULTS; i++) begin
        if (cmd.flag_set && (fault_index == IDX_W'(i))) begin
          flags_r[i] <= 1'b1;
        end
        if (cmd.flag_clr && (fault_index == IDX_W'(i))) begin
          flags_r[i] <= 1'b0;
        end
      end
      if (cmd.capture && (service_id == SID_CLEAR_DTC)) begin
        flags_r <= '0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request capture, sequencing counters and output payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sid_r     <= service_id;
      sub_r     <= sub_function;
      has_sub_r <= request_length[1];
      pos_r     <= POS_FIRST;
      trip_r    <= '0;
    end
    if (cmd.emit_msg) begin
      out_byte_r <= msg_byte;
      out_last_r <= sts.msg_last && !sts.dtc_more;
      if (sts.msg_last) begin
        pos_r <= POS_FIRST;
        ptr_r <= first_fa[PTR_W-1:0];
      end else begin
        pos_r <= pos_r + 2'd1;
      end
    end
    if (cmd.emit_trip) begin
      out_byte_r <= trip_byte;
      out_last_r <= sts.trip_end && !sts.trip_more;
      if (sts.trip_end) begin
        pos_r  <= POS_FIRST;
        ptr_r  <= after_fa[PTR_W-1:0];
        trip_r <= trip_r + TRIP_W'(1);
      end else begin
        pos_r <= pos_r + 2'd1;
      end
    end
  end

  assign out_tvalid    = out_valid_r;
  assign response_byte = out_byte_r;
  assign last_byte     = out_last_r;

endmodule

// ===== rtl/core/uds_fault_table_responder_core.sv =====
// Record and clear items update the fault flags register on acceptance, with no result.
// A request is captured, then its response bytes are loaded into the output register,
// one per cycle unless the output stalls. Throughput: record/clear one beat a cycle; a
// request of nonzero length holds the input closed until its 1 to 16 bytes are loaded.
// Reset (rst_n low, synchronous): all fault flags cleared, controller idle, no output.
`timescale 1ns / 1ps
`include "uds_fault_table_responder_core_macros.svh"
module uds_fault_table_responder_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [2:0] fault_index, [4:3] request_length, [12:5] service_id, [20:13] sub_function
  input  logic [ufr_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] command
  input  logic [ufr_pkg::CMD_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] response_byte
  output logic [ufr_pkg::OUT_TDATA_W-1:0] out_tdata,
  // last_byte
  output logic                            out_tlast
);
  import ufr_pkg::*;

  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic [IDX_W-1:0]   fault_index;
  logic [LEN_W-1:0]   request_length;
  logic [BYTE_W-1:0]  service_id, sub_function;
  logic               req_accept;

  // Input beat field split
  assign fault_index    = in_tdata[IDX_LSB +: IDX_W];
  assign request_length = in_tdata[LEN_LSB +: LEN_W];
  assign service_id     = in_tdata[SID_LSB +: BYTE_W];
  assign sub_function   = in_tdata[SUB_LSB +: BYTE_W];

  ufr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_command (in_tuser),
    .in_len_nz  (|request_length),
    .sts        (sts),
    .cmd        (cmd)
  );

  ufr_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .fault_index    (fault_index),
    .request_length (request_length),
    .service_id     (service_id),
    .sub_function   (sub_function),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .response_byte  (out_tdata),
    .last_byte      (out_tlast),
    .sts            (sts)
  );

  // Checks
  assign req_accept = in_tvalid && in_tready && (in_tuser == CMD_REQUEST) &&
                      (request_length != '0);

  `UFR_ASSERT_NEXT(a_req_closes_input, req_accept, !in_tready, "input open during response")
  `UFR_ASSERT_LATER(a_req_gives_beat, req_accept, out_tvalid, "no response beat after request")
  `UFR_ASSERT_SAME(a_midmsg_busy, out_tvalid && !out_tlast, !in_tready, "input open mid response")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the fault table responder core.
`timescale 1ns / 1ps
module testbench;
  import ufr_pkg::*;

  // Unused command code; the block must ignore it
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 4;
  localparam int IDLE_PCT     = 15;
  localparam int CALM_ITEMS   = 60;
  localparam int RANDOM_ITEMS = 200;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } resp_beat_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // [2:0] fault_index, [4:3] request_length, [12:5] service_id, [20:13] sub_function
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  // [1:0] command
  logic [CMD_W-1:0]       in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [7:0] response_byte
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  // Predictor state and expected response bytes
  logic [NUM_FAULTS-1:0]  fault_flags = '0;
  resp_beat_t             resp_bytes_q[$];

  int unsigned cycle_count   = 0;
  int unsigned error_count   = 0;
  int unsigned items_sent    = 0;
  int unsigned requests_sent = 0;
  int unsigned bytes_checked = 0;
  int unsigned tx_idle_pct   = 0;
  int unsigned rx_idle_pct   = 0;
  logic        hold_request  = 1'b0;

  uds_fault_table_responder_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #CLK_HALF clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d bytes still expected",
               cycle_count, resp_bytes_q.size());
      $display("uds_fault_table_responder_core: mismatch");
      $finish;
    end
  end

  // One response byte that is not the last of its message
  function automatic resp_beat_t beat_of(input logic [BYTE_W-1:0] value);
    return '{data: value, last: 1'b0};
  endfunction

  // Fault table and response builder for one accepted beat
  function automatic void predict_response(input logic [CMD_W-1:0] cmd,
                                           input logic [IDX_W-1:0] idx,
                                           input logic [LEN_W-1:0] len,
                                           input logic [BYTE_W-1:0] sid,
                                           input logic [BYTE_W-1:0] sub);
    resp_beat_t  msg[$];
    logic [15:0] code;
    case (cmd)
      CMD_RECORD: begin
        if (idx < NUM_FAULTS) fault_flags[idx] = 1'b1;
      end
      CMD_CLEAR: begin
        if (idx < NUM_FAULTS) fault_flags[idx] = 1'b0;
      end
      CMD_REQUEST: begin
        if (len != '0) begin
          if (sid == SID_SESSION) begin
            if (len >= 2) begin
              msg.insert(msg.size(), beat_of(RSP_SESSION));
              msg.insert(msg.size(), beat_of(sub));
            end else begin
              msg.insert(msg.size(), beat_of(NEG_RESPONSE));
              msg.insert(msg.size(), beat_of(sid));
              msg.insert(msg.size(), beat_of(NRC_BAD_LENGTH));
            end
          end else if (sid == SID_READ_DTC) begin
            msg.insert(msg.size(), beat_of(RSP_READ_DTC));
            for (int i = 0; i < NUM_FAULTS; i++) begin
              // whole triples only; anything past the message limit is dropped
              if (fault_flags[i] && msg.size() + 3 <= MAX_RESULTS) begin
                code = FAULT_CODE_BASE + 16'(i);
                msg.insert(msg.size(), beat_of(code[15:8]));
                msg.insert(msg.size(), beat_of(code[7:0]));
                msg.insert(msg.size(), beat_of(STATUS_ACTIVE));
              end
            end
          end else if (sid == SID_CLEAR_DTC) begin
            fault_flags = '0;
            msg.insert(msg.size(), beat_of(RSP_CLEAR_DTC));
          end else begin
            msg.insert(msg.size(), beat_of(NEG_RESPONSE));
            msg.insert(msg.size(), beat_of(sid));
            msg.insert(msg.size(), beat_of(NRC_NOT_SUPPORTED));
          end
          msg[msg.size() - 1].last = 1'b1;
          foreach (msg[k]) resp_bytes_q.insert(resp_bytes_q.size(), msg[k]);
        end
      end
      default: ;
    endcase
  endfunction

  // Input monitor and response checker, sampled at the clock edge
  always @(posedge clk) begin
    resp_beat_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_response(in_tuser, in_tdata[IDX_LSB +: IDX_W], in_tdata[LEN_LSB +: LEN_W],
                         in_tdata[SID_LSB +: BYTE_W], in_tdata[SUB_LSB +: BYTE_W]);
      end
      if (out_tvalid && out_tready) begin
        bytes_checked++;
        if (resp_bytes_q.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("[%0d] unexpected beat: data=%02h last=%0b",
                     cycle_count, out_tdata, out_tlast);
        end else begin
          want = resp_bytes_q.pop_front();
          if (out_tdata !== want.data || out_tlast !== want.last) begin
            error_count++;
            if (error_count <= REPORT_MAX)
              $display("[%0d] beat mismatch: expected data=%02h last=%0b, got data=%02h last=%0b",
                       cycle_count, want.data, want.last, out_tdata, out_tlast);
          end
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_tready <= 1'b0;
          @(posedge clk);
        end
      end
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offer one beat, with an optional idle gap first; returns on acceptance
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                           input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] sid,
                           input logic [BYTE_W-1:0] sub);
    int unsigned gap;
    if ($urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(4, 1);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_TDATA_W - SUB_LSB - BYTE_W){1'b0}}, sub, sid, len, idx};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (cmd == CMD_REQUEST) requests_sent++;
  endtask

  // Record and clear, in and out of the table, read back after each group of updates
  task automatic test_fault_table();
    send_item(CMD_REQUEST, 3'd0, 2'd1, SID_READ_DTC, 8'h00);
    for (int i = 0; i < NUM_FAULTS; i++) send_item(CMD_RECORD, IDX_W'(i), 2'd0, 8'h00, 8'h00);
    send_item(CMD_RECORD, 3'd7, 2'd3, 8'hFF, 8'hFF);
    send_item(CMD_REQUEST, 3'd7, 2'd2, SID_READ_DTC, 8'hFF);
    send_item(CMD_CLEAR, 3'd2, 2'd0, 8'h00, 8'h00);
    send_item(CMD_CLEAR, 3'd5, 2'd0, 8'h00, 8'h00);
    send_item(CMD_REQUEST, 3'd0, 2'd1, SID_READ_DTC, 8'h00);
  endtask

  // Session control with and without the sub byte, and a saturated length
  task automatic test_session_service();
    send_item(CMD_REQUEST, 3'd0, 2'd2, SID_SESSION, 8'hFF);
    send_item(CMD_REQUEST, 3'd0, 2'd1, SID_SESSION, 8'hAA);
    send_item(CMD_REQUEST, 3'd0, 2'd3, SID_SESSION, 8'h00);
  endtask

  // Clear-all service, then an empty read
  task automatic test_clear_service();
    send_item(CMD_REQUEST, 3'd0, 2'd1, SID_CLEAR_DTC, 8'h00);
    send_item(CMD_REQUEST, 3'd0, 2'd1, SID_READ_DTC, 8'h00);
  endtask

  // Unsupported services, empty request, unused command
  task automatic test_ignored_and_rejected();
    send_item(CMD_RECORD, 3'd1, 2'd0, 8'h00, 8'h00);
    send_item(CMD_REQUEST, 3'd0, 2'd1, 8'h00, 8'h00);
    send_item(CMD_REQUEST, 3'd7, 2'd2, 8'hFF, 8'hFF);
    send_item(CMD_REQUEST, 3'd0, 2'd0, SID_READ_DTC, 8'h00);
    send_item(CMD_UNUSED, 3'd1, 2'd2, SID_CLEAR_DTC, 8'h00);
    send_item(CMD_REQUEST, 3'd0, 2'd1, SID_READ_DTC, 8'h00);
  endtask

  // Mixed traffic: a calm stretch first, then random idling on both sides
  task automatic test_random_traffic(input int count);
    int unsigned      pick;
    logic [CMD_W-1:0] cmd;
    logic [BYTE_W-1:0] sid;
    for (int n = 0; n < count; n++) begin
      if (n == CALM_ITEMS) begin
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
      end
      pick = $urandom_range(99);
      if (pick < 35)      cmd = CMD_RECORD;
      else if (pick < 60) cmd = CMD_CLEAR;
      else if (pick < 95) cmd = CMD_REQUEST;
      else                cmd = CMD_UNUSED;
      pick = $urandom_range(9);
      if (pick < 3)       sid = SID_SESSION;
      else if (pick < 6)  sid = SID_READ_DTC;
      else if (pick == 6) sid = SID_CLEAR_DTC;
      else                sid = BYTE_W'($urandom);
      send_item(cmd, IDX_W'($urandom_range(7)), LEN_W'($urandom_range(3)), sid,
                BYTE_W'($urandom));
    end
  endtask

  // Receiver holds off while the sender keeps offering a full read and more
  task automatic test_output_backpressure();
    for (int i = 0; i < NUM_FAULTS; i++) send_item(CMD_RECORD, IDX_W'(i), 2'd0, 8'h00, 8'h00);
    hold_request = 1'b1;
    send_item(CMD_REQUEST, 3'd0, 2'd2, SID_READ_DTC, 8'h00);
    send_item(CMD_REQUEST, 3'd0, 2'd2, SID_SESSION, 8'h5A);
    send_item(CMD_CLEAR, 3'd0, 2'd0, 8'h00, 8'h00);
    send_item(CMD_REQUEST, 3'd0, 2'd1, SID_READ_DTC, 8'h00);
    send_item(CMD_REQUEST, 3'd0, 2'd1, 8'h22, 8'h00);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fault_table();
    test_session_service();
    test_clear_service();
    test_ignored_and_rejected();
    test_random_traffic(RANDOM_ITEMS);
    test_output_backpressure();

    // Drain outstanding response bytes, then let the block settle
    in_tvalid <= 1'b0;
    while (resp_bytes_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d input beats (%0d diagnostic requests), checked %0d response bytes.",
             items_sent, requests_sent, bytes_checked);
    $display("Covered table updates in and out of range, every service, stalls, hold-off: %0d errors.",
             error_count);
    if (error_count == 0 && resp_bytes_q.size() == 0) begin
      $display("uds_fault_table_responder_core: match");
    end else begin
      $display("uds_fault_table_responder_core: mismatch");
    end
    $finish;
  end

endmodule
